[rtl/core/h264fu_pkg.sv]
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer package
// Shared types, register indexes, byte positions and protocol constants.
// ----------------------------------------------------------------------------
package h264fu_pkg;

    localparam int unsigned MAX_UNIT_BYTES = 1048576;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 21;
    localparam int unsigned FRAG_W   = 13;
    localparam int unsigned SEQ_W    = 16;
    localparam int unsigned TS_W     = 32;
    localparam int unsigned PT_W     = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TS_STEP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAG       = 3'd4;

    // Register reset values.
    localparam logic [PT_W-1:0]   PT_RESET       = 7'd96;
    localparam logic [TS_W-1:0]   TS_STEP_RESET  = 32'(90000 / 25);
    localparam logic [FRAG_W-1:0] MAX_FRAG_RESET = 13'd1400;
    localparam logic [FRAG_W-1:0] MAX_FRAG_LIMIT = 13'd4096;

    // Protocol constants.
    localparam logic [7:0] INTERLEAVE_MAGIC = 8'h24;
    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] NRI_MASK         = 8'h60;
    localparam logic [7:0] TYPE_MASK        = 8'h1F;
    localparam logic [7:0] FU_A_TYPE        = 8'd28;
    localparam logic [7:0] FU_START_BIT     = 8'h80;
    localparam logic [7:0] FU_END_BIT       = 8'h40;
    localparam logic [4:0] NAL_TYPE_SPS     = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS     = 5'd8;
    localparam logic [15:0] RTP_HDR_BYTES   = 16'd12;
    localparam logic [15:0] FU_HDR_BYTES    = 16'd14;

    // Byte positions within one emitted request group.
    typedef logic [4:0] pos_t;
    localparam pos_t POS_MAGIC   = 5'd0;
    localparam pos_t POS_CHANNEL = 5'd1;
    localparam pos_t POS_LEN_HI  = 5'd2;
    localparam pos_t POS_LEN_LO  = 5'd3;
    localparam pos_t POS_VER     = 5'd4;
    localparam pos_t POS_PT      = 5'd5;
    localparam pos_t POS_SEQ_HI  = 5'd6;
    localparam pos_t POS_SEQ_LO  = 5'd7;
    localparam pos_t POS_TS_3    = 5'd8;
    localparam pos_t POS_TS_2    = 5'd9;
    localparam pos_t POS_TS_1    = 5'd10;
    localparam pos_t POS_TS_0    = 5'd11;
    localparam pos_t POS_SSRC_3  = 5'd12;
    localparam pos_t POS_SSRC_2  = 5'd13;
    localparam pos_t POS_SSRC_1  = 5'd14;
    localparam pos_t POS_SSRC_0  = 5'd15;
    localparam pos_t POS_FU_IND  = 5'd16;
    localparam pos_t POS_FU_HDR  = 5'd17;
    localparam pos_t POS_PAYLOAD = 5'd18;

    typedef struct packed {
        logic [BYTE_W-1:0] nal_byte;
        logic              nal_first;
        logic [LEN_W-1:0]  nal_length;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              packet_last;
        logic              unit_last;
    } out_t;

    // Everything needed to emit the bytes caused by one input byte.
    typedef struct packed {
        logic              hdr;
        logic              fu;
        logic [15:0]       rtp_len;
        logic [SEQ_W-1:0]  seq;
        logic [TS_W-1:0]   ts;
        logic [BYTE_W-1:0] fu_ind;
        logic [BYTE_W-1:0] fu_hdr;
        logic [BYTE_W-1:0] payload;
        logic              pl;
        logic              ul;
    } job_t;

endpackage

[rtl/core/h264_rtp_fu_packetizer_top.sv]
// ----------------------------------------------------------------------------
// H.264 RTP FU-A packetizer, interleaved framing
// Turns a byte stream of NAL units into RTP-over-TCP interleaved packets.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one NAL byte per request; nal_length is sampled on
//   the header byte (nal_first = 1). The m_ channel delivers the packet
//   stream one byte per request, with packet_last and unit_last flags.
//   Registers are written through cfg_we/cfg_index/cfg_wdata while idle.
// Flow:
//   A byte is decided in the cycle it is accepted; its first output byte
//   goes through the group register, then the output byte register.
//   Payload bytes inside a packet flow at one per cycle while m_ready is
//   high. A byte that opens a packet causes 17 output bytes (whole unit) or
//   19 (FU-A fragment); the input is held until its payload byte is sent.
//   A fragmented unit's header byte and bytes with no unit open emit nothing.
// Reset:
//   aresetn is synchronous and active low; it clears sequence, timestamp and
//   unit tracking and restores the register defaults.
// Stall:
//   While m_ready is low the output byte holds; the pending group waits and
//   s_ready drops once a group is pending.
// ----------------------------------------------------------------------------
module h264_rtp_fu_packetizer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  h264fu_pkg::in_t               s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output h264fu_pkg::out_t              m_data,
    input  logic                          cfg_we,
    input  logic [h264fu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [h264fu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import h264fu_pkg::*;

    // Configuration registers.
    logic [PT_W-1:0]   pt_reg;
    logic [31:0]       ssrc_reg;
    logic [7:0]        chan_reg;
    logic [TS_W-1:0]   ts_step_reg;
    logic [FRAG_W-1:0] max_frag_reg;

    // Packetizer state.
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [LEN_W-1:0]  unit_left_reg, unit_left_next;
    logic [FRAG_W-1:0] pkt_left_reg, pkt_left_next;
    logic [7:0]        hdr_copy_reg, hdr_copy_next;
    logic              frag_mode_reg, frag_mode_next;
    logic              first_frag_reg, first_frag_next;

    // Pending output group and output register.
    job_t  job_reg, job_next;
    logic  job_valid_reg, job_valid_next;
    pos_t  idx_reg, idx_next;
    logic  m_valid_reg, m_valid_next;
    out_t  m_data_reg, m_data_next;

    logic              out_free, emit, job_done, s_accept, job_load;
    logic [FRAG_W-1:0] lim;
    logic [LEN_W-1:0]  len;
    logic [FRAG_W-1:0] frag_sz;
    logic [FRAG_W-1:0] pbl, pbl_d;
    logic [LEN_W-1:0]  ubl, ubl_d;
    logic              do_payload, pl, ul;
    logic [4:0]        nal_type;
    out_t              emit_data;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = job_valid_reg && out_free;
    assign job_done = emit && (idx_reg == POS_PAYLOAD);
    assign s_ready  = !job_valid_reg || job_done;
    assign s_accept = s_valid && s_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Payload size limit, clamped into 1..4096.
    always_comb begin
        if (max_frag_reg == '0) begin
            lim = FRAG_W'(1);
        end else if (max_frag_reg > MAX_FRAG_LIMIT) begin
            lim = MAX_FRAG_LIMIT;
        end else begin
            lim = max_frag_reg;
        end
    end

    // Unit length, clamped into 1..MAX_UNIT_BYTES.
    always_comb begin
        if (s_data.nal_length == '0) begin
            len = LEN_W'(1);
        end else if (s_data.nal_length > LEN_W'(MAX_UNIT_BYTES)) begin
            len = LEN_W'(MAX_UNIT_BYTES);
        end else begin
            len = s_data.nal_length;
        end
    end

    assign frag_sz = (unit_left_reg < LEN_W'(lim)) ? FRAG_W'(unit_left_reg) : lim;

    // Decide everything one accepted byte does to the state.
    always_comb begin
        seq_next        = seq_reg;
        ts_next         = ts_reg;
        unit_left_next  = unit_left_reg;
        pkt_left_next   = pkt_left_reg;
        hdr_copy_next   = hdr_copy_reg;
        frag_mode_next  = frag_mode_reg;
        first_frag_next = first_frag_reg;
        job_load        = 1'b0;
        do_payload      = 1'b0;
        pbl             = pkt_left_reg;
        ubl             = unit_left_reg;
        pbl_d           = '0;
        ubl_d           = '0;
        pl              = 1'b0;
        ul              = 1'b0;
        nal_type        = '0;
        job_next        = job_reg;

        if (s_accept) begin
            job_next.hdr     = 1'b0;
            job_next.fu      = 1'b0;
            job_next.seq     = seq_reg;
            job_next.ts      = ts_reg;
            job_next.payload = s_data.nal_byte;
            if (s_data.nal_first) begin
                hdr_copy_next = s_data.nal_byte;
                if (len <= LEN_W'(lim)) begin
                    frag_mode_next   = 1'b0;
                    first_frag_next  = 1'b0;
                    job_next.hdr     = 1'b1;
                    job_next.rtp_len = RTP_HDR_BYTES + 16'(len);
                    pbl              = FRAG_W'(len);
                    ubl              = len;
                    do_payload       = 1'b1;
                end else begin
                    // Fragmented unit: the header byte is kept, not sent.
                    frag_mode_next  = 1'b1;
                    first_frag_next = 1'b1;
                    unit_left_next  = len - LEN_W'(1);
                    pkt_left_next   = '0;
                end
            end else if (unit_left_reg != '0) begin
                do_payload = 1'b1;
                if (pkt_left_reg == '0) begin
                    first_frag_next  = 1'b0;
                    job_next.hdr     = 1'b1;
                    job_next.fu      = 1'b1;
                    job_next.rtp_len = FU_HDR_BYTES + 16'(frag_sz);
                    job_next.fu_ind  = (hdr_copy_reg & NRI_MASK) | FU_A_TYPE;
                    job_next.fu_hdr  = (hdr_copy_reg & TYPE_MASK)
                                     | (first_frag_reg ? FU_START_BIT : 8'h00)
                                     | ((unit_left_reg <= LEN_W'(lim)) ? FU_END_BIT : 8'h00);
                    pbl              = frag_sz;
                end
            end

            if (do_payload) begin
                pbl_d          = (pbl != '0) ? pbl - FRAG_W'(1) : pbl;
                ubl_d          = (ubl != '0) ? ubl - LEN_W'(1) : ubl;
                pl             = (pbl_d == '0);
                ul             = (ubl_d == '0);
                pkt_left_next  = pbl_d;
                unit_left_next = ubl_d;
                nal_type       = hdr_copy_next[4:0];
                if (pl) begin
                    seq_next = seq_reg + SEQ_W'(1);
                end
                // Parameter sets sent whole share the timestamp of the next frame.
                if (ul && (frag_mode_next ||
                           (nal_type != NAL_TYPE_SPS && nal_type != NAL_TYPE_PPS))) begin
                    ts_next = ts_reg + ts_step_reg;
                end
                job_next.pl = pl;
                job_next.ul = ul;
                job_load    = 1'b1;
            end
        end
    end

    // Byte selection for the current position of the pending group.
    always_comb begin
        emit_data = '0;
        unique case (idx_reg)
            POS_MAGIC:   emit_data.out_byte = INTERLEAVE_MAGIC;
            POS_CHANNEL: emit_data.out_byte = chan_reg;
            POS_LEN_HI:  emit_data.out_byte = job_reg.rtp_len[15:8];
            POS_LEN_LO:  emit_data.out_byte = job_reg.rtp_len[7:0];
            POS_VER:     emit_data.out_byte = RTP_VERSION_BYTE;
            POS_PT:      emit_data.out_byte = {1'b0, pt_reg};
            POS_SEQ_HI:  emit_data.out_byte = job_reg.seq[15:8];
            POS_SEQ_LO:  emit_data.out_byte = job_reg.seq[7:0];
            POS_TS_3:    emit_data.out_byte = job_reg.ts[31:24];
            POS_TS_2:    emit_data.out_byte = job_reg.ts[23:16];
            POS_TS_1:    emit_data.out_byte = job_reg.ts[15:8];
            POS_TS_0:    emit_data.out_byte = job_reg.ts[7:0];
            POS_SSRC_3:  emit_data.out_byte = ssrc_reg[31:24];
            POS_SSRC_2:  emit_data.out_byte = ssrc_reg[23:16];
            POS_SSRC_1:  emit_data.out_byte = ssrc_reg[15:8];
            POS_SSRC_0:  emit_data.out_byte = ssrc_reg[7:0];
            POS_FU_IND:  emit_data.out_byte = job_reg.fu_ind;
            POS_FU_HDR:  emit_data.out_byte = job_reg.fu_hdr;
            POS_PAYLOAD: begin
                emit_data.out_byte    = job_reg.payload;
                emit_data.packet_last = job_reg.pl;
                emit_data.unit_last   = job_reg.ul;
            end
            default:     emit_data = '0;
        endcase
    end

    // Group sequencing and output register control.
    always_comb begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
            if (idx_reg == POS_SSRC_0) begin
                idx_next = job_reg.fu ? POS_FU_IND : POS_PAYLOAD;
            end else begin
                idx_next = idx_reg + pos_t'(1);
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (job_load) begin
            job_valid_next = 1'b1;
            idx_next       = job_next.hdr ? POS_MAGIC : POS_PAYLOAD;
        end else if (job_done) begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_reg         <= PT_RESET;
            ssrc_reg       <= '0;
            chan_reg       <= '0;
            ts_step_reg    <= TS_STEP_RESET;
            max_frag_reg   <= MAX_FRAG_RESET;
            seq_reg        <= '0;
            ts_reg         <= '0;
            unit_left_reg  <= '0;
            pkt_left_reg   <= '0;
            hdr_copy_reg   <= '0;
            frag_mode_reg  <= 1'b0;
            first_frag_reg <= 1'b0;
            job_valid_reg  <= 1'b0;
            idx_reg        <= POS_MAGIC;
            m_valid_reg    <= 1'b0;
        end else begin
            seq_reg        <= seq_next;
            ts_reg         <= ts_next;
            unit_left_reg  <= unit_left_next;
            pkt_left_reg   <= pkt_left_next;
            hdr_copy_reg   <= hdr_copy_next;
            frag_mode_reg  <= frag_mode_next;
            first_frag_reg <= first_frag_next;
            job_valid_reg  <= job_valid_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PAYLOAD_TYPE: pt_reg       <= cfg_wdata[PT_W-1:0];
                    CFG_SSRC:         ssrc_reg     <= cfg_wdata;
                    CFG_CHANNEL:      chan_reg     <= cfg_wdata[7:0];
                    CFG_TS_STEP:      ts_step_reg  <= cfg_wdata;
                    CFG_MAX_FRAG:     max_frag_reg <= cfg_wdata[FRAG_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

    // A packet never has bytes left once its unit is exhausted.
    a_pkt_within_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (unit_left_reg == '0) |-> (pkt_left_reg == '0))
        else $error("packet byte count exceeds unit byte count");

    // The position counter stays within a group while one is pending.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> (idx_reg <= POS_PAYLOAD))
        else $error("byte position out of range");

    // FU bytes are only emitted for fragment groups.
    a_fu_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && (idx_reg == POS_FU_IND || idx_reg == POS_FU_HDR))
        |-> job_reg.fu)
        else $error("FU byte position in a whole-unit group");

    // The end of a unit is always the end of a packet.
    a_unit_ends_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.unit_last) |-> m_data_reg.packet_last)
        else $error("unit ended inside a packet");

    // A finished group hands its payload byte to the output register.
    a_done_outputs: assert property (@(posedge aclk) disable iff (!aresetn)
        job_done |=> m_valid_reg)
        else $error("payload byte lost at end of group");

endmodule
